[src/spq_pkg.sv]
`default_nettype none

package spq_pkg;

   // Field widths fixed by the interface.
   localparam int VALUE_W = 32;
   localparam int PRIO_W = 16;
   localparam int FILL_W = 5;

   // Default number of cells in the chain.
   localparam int DEPTH_DEFAULT = 16;

   // Operation codes carried in a request beat.
   typedef enum logic [0:0] {
      OP_ENQUEUE = 1'b0,
      OP_DEQUEUE = 1'b1
   } op_type;

   // Command broadcast to every cell of the chain in one cycle.
   typedef struct packed {
      logic                      enq;
      logic                      deq;
      logic signed [VALUE_W-1:0] value;
      logic signed [PRIO_W-1:0]  prio;
   } bcast_type;

endpackage

`default_nettype wire

[src/sorted_priority_queue.sv]
// Result: each result beat is registered from its accepted request beat.
// Throughput: one request beat per cycle while result beats are taken; all cells compare
// and shift in parallel, and the output register frees as its beat is taken.
// Reset: synchronous, active high; clears the entry count and the result valid flag.
// Cell contents are not cleared; cells at or beyond the count are never reported.
`default_nettype none

module sorted_priority_queue #(
   parameter int DEPTH = spq_pkg::DEPTH_DEFAULT
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic                               req_op,
   input  wire logic signed [spq_pkg::VALUE_W-1:0] req_value,
   input  wire logic signed [spq_pkg::PRIO_W-1:0]  req_priority_req,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic                                    rsp_out_valid,
   output logic signed [spq_pkg::VALUE_W-1:0]      rsp_out_value,
   output logic signed [spq_pkg::PRIO_W-1:0]       rsp_out_priority,
   output logic                                    rsp_underflow,
   output logic                                    rsp_overflow,
   output logic [spq_pkg::FILL_W-1:0]              rsp_fill_count
);
   import spq_pkg::*;

   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [CNT_W-1:0]          count_ff;
   logic [CNT_W-1:0]          count_in;
   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   logic                      out_valid_ff;
   logic                      out_valid_in;
   logic signed [VALUE_W-1:0] out_value_ff;
   logic signed [VALUE_W-1:0] out_value_in;
   logic signed [PRIO_W-1:0]  out_prio_ff;
   logic signed [PRIO_W-1:0]  out_prio_in;
   logic                      under_ff;
   logic                      under_in;
   logic                      over_ff;
   logic                      over_in;
   logic [FILL_W-1:0]         fill_ff;
   logic [FILL_W-1:0]         fill_in;

   logic                      accept;
   logic                      full;
   logic                      empty;
   bcast_type                 bcast;

   logic                      occupied [DEPTH];
   logic                      keep [DEPTH];
   logic signed [VALUE_W-1:0] cell_value [DEPTH];
   logic signed [PRIO_W-1:0]  cell_prio [DEPTH];

   // The output register takes a new beat when it is empty or being drained.
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept = req_valid && req_ready;
   assign full = (count_ff == CNT_W'(DEPTH));
   assign empty = (count_ff == '0);

   // Command to the chain; an enqueue to a full queue or a dequeue from an empty one leaves the cells unchanged.
   always_comb begin
      bcast.enq = accept && (req_op == OP_ENQUEUE) && !full;
      bcast.deq = accept && (req_op == OP_DEQUEUE) && !empty;
      bcast.value = req_value;
      bcast.prio = req_priority_req;
   end

   // Chain of cells, head at index zero.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic                      left_keep;
      logic signed [VALUE_W-1:0] left_value;
      logic signed [PRIO_W-1:0]  left_prio;
      logic signed [VALUE_W-1:0] right_value;
      logic signed [PRIO_W-1:0]  right_prio;

      assign occupied[i] = (CNT_W'(i) < count_ff);

      if (i == 0) begin : g_head
         assign left_keep = 1'b1;
         assign left_value = '0;
         assign left_prio = '0;
      end else begin : g_body
         assign left_keep = keep[i-1];
         assign left_value = cell_value[i-1];
         assign left_prio = cell_prio[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign right_value = '0;
         assign right_prio = '0;
      end else begin : g_inner
         assign right_value = cell_value[i+1];
         assign right_prio = cell_prio[i+1];
      end

      spq_cell u_cell (
         .clock       (clock),
         .bcast       (bcast),
         .occupied    (occupied[i]),
         .left_keep   (left_keep),
         .left_value  (left_value),
         .left_prio   (left_prio),
         .right_value (right_value),
         .right_prio  (right_prio),
         .keep        (keep[i]),
         .value       (cell_value[i]),
         .prio        (cell_prio[i])
      );
   end

   // Entry count and the result beat.
   always_comb begin
      count_in = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      out_valid_in = out_valid_ff;
      out_value_in = out_value_ff;
      out_prio_in = out_prio_ff;
      under_in = under_ff;
      over_in = over_ff;
      fill_in = fill_ff;
      if (bcast.enq) begin
         count_in = count_ff + CNT_W'(1);
      end else if (bcast.deq) begin
         count_in = count_ff - CNT_W'(1);
      end
      if (accept) begin
         rsp_valid_in = 1'b1;
         out_valid_in = bcast.deq;
         out_value_in = bcast.deq ? cell_value[0] : '0;
         out_prio_in = bcast.deq ? cell_prio[0] : '0;
         under_in = (req_op == OP_DEQUEUE) && empty;
         over_in = (req_op == OP_ENQUEUE) && full;
         fill_in = FILL_W'(count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_valid_ff <= out_valid_in;
      out_value_ff <= out_value_in;
      out_prio_ff <= out_prio_in;
      under_ff <= under_in;
      over_ff <= over_in;
      fill_ff <= fill_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_out_valid = out_valid_ff;
   assign rsp_out_value = out_value_ff;
   assign rsp_out_priority = out_prio_ff;
   assign rsp_underflow = under_ff;
   assign rsp_overflow = over_ff;
   assign rsp_fill_count = fill_ff;

endmodule

`default_nettype wire

[src/spq_cell.sv]
`default_nettype none

module spq_cell (
   input  wire logic                               clock,
   input  wire spq_pkg::bcast_type                 bcast,
   input  wire logic                               occupied,
   input  wire logic                               left_keep,
   input  wire logic signed [spq_pkg::VALUE_W-1:0] left_value,
   input  wire logic signed [spq_pkg::PRIO_W-1:0]  left_prio,
   input  wire logic signed [spq_pkg::VALUE_W-1:0] right_value,
   input  wire logic signed [spq_pkg::PRIO_W-1:0]  right_prio,
   output logic                                    keep,
   output logic signed [spq_pkg::VALUE_W-1:0]      value,
   output logic signed [spq_pkg::PRIO_W-1:0]       prio
);
   import spq_pkg::*;

   logic signed [VALUE_W-1:0] value_ff;
   logic signed [VALUE_W-1:0] value_in;
   logic signed [PRIO_W-1:0]  prio_ff;
   logic signed [PRIO_W-1:0]  prio_in;

   // A held entry of equal or higher priority stays ahead of the new one.
   assign keep = occupied && (prio_ff >= bcast.prio);

   // Hold, take the new entry, shift down on insert or shift up on removal.
   always_comb begin
      value_in = value_ff;
      prio_in = prio_ff;
      if (bcast.enq) begin
         if (!keep) begin
            if (left_keep) begin
               value_in = bcast.value;
               prio_in = bcast.prio;
            end else begin
               value_in = left_value;
               prio_in = left_prio;
            end
         end
      end else if (bcast.deq) begin
         value_in = right_value;
         prio_in = right_prio;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      prio_ff <= prio_in;
   end

   assign value = value_ff;
   assign prio = prio_ff;

endmodule

`default_nettype wire

[tb/tb_sorted_priority_queue.sv]
`timescale 1ns / 100ps

module tb_sorted_priority_queue;
   import spq_pkg::*;

   localparam int DEPTH = DEPTH_DEFAULT;
   localparam int HOLD_CYCLES = 250;
   localparam int RANDOM_PHASES = 16;
   localparam int PHASE_ITEMS = 102;
   localparam longint LIMIT_NS = 64'd6_000_000;

   // One result beat, field for field as the block presents it.
   typedef struct packed {
      logic                      out_valid;
      logic signed [VALUE_W-1:0] out_value;
      logic signed [PRIO_W-1:0]  out_priority;
      logic                      underflow;
      logic                      overflow;
      logic [FILL_W-1:0]         fill_count;
   } queue_result_type;

   // Scoreboard: keeps its own sorted copy of the queue contents and the
   // results still owed by the block.
   class spq_scoreboard;
      logic signed [VALUE_W-1:0] held_value[$];
      logic signed [PRIO_W-1:0]  held_prio[$];
      queue_result_type          owed_results[$];
      int mismatches;
      int enqueues;
      int dequeues;
      int overflows;
      int underflows;
      int results_checked;
      int peak_fill;

      task report_mismatch(input string msg);
         $display("MISMATCH at %0t ns: %s", $time, msg);
         mismatches++;
      endtask

      // Apply one accepted request beat to the sorted store and queue its result.
      function void note_request(input op_type op, input logic signed [VALUE_W-1:0] value,
                                 input logic signed [PRIO_W-1:0] prio);
         queue_result_type r;
         int pos;
         r = '0;
         if (op == OP_ENQUEUE) begin
            enqueues++;
            if (held_prio.size() >= DEPTH) begin
               r.overflow = 1'b1;
               overflows++;
            end else begin
               // A new entry goes behind every entry of greater or equal priority.
               pos = 0;
               while (pos < held_prio.size() && held_prio[pos] >= prio)
                  pos++;
               held_value.insert(pos, value);
               held_prio.insert(pos, prio);
            end
         end else begin
            dequeues++;
            if (held_prio.size() == 0) begin
               r.underflow = 1'b1;
               underflows++;
            end else begin
               r.out_valid = 1'b1;
               r.out_value = held_value.pop_front();
               r.out_priority = held_prio.pop_front();
            end
         end
         r.fill_count = FILL_W'(held_prio.size());
         if (held_prio.size() > peak_fill)
            peak_fill = held_prio.size();
         owed_results.push_back(r);
      endfunction

      task compare_field(input string name, input logic [VALUE_W-1:0] got,
                         input logic [VALUE_W-1:0] want);
         if (got !== want)
            report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
      endtask

      // Compare an accepted result beat with the oldest one owed.
      task check_response(input queue_result_type got);
         queue_result_type want;
         if (owed_results.size() == 0) begin
            report_mismatch("result beat arrived with nothing outstanding");
            return;
         end
         want = owed_results.pop_front();
         results_checked++;
         compare_field("out_valid", 32'(got.out_valid), 32'(want.out_valid));
         compare_field("out_value", got.out_value, want.out_value);
         compare_field("out_priority", 32'(got.out_priority), 32'(want.out_priority));
         compare_field("underflow", 32'(got.underflow), 32'(want.underflow));
         compare_field("overflow", 32'(got.overflow), 32'(want.overflow));
         compare_field("fill_count", 32'(got.fill_count), 32'(want.fill_count));
      endtask
   endclass

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      req_valid;
   logic                      req_ready;
   logic                      req_op;
   logic signed [VALUE_W-1:0] req_value;
   logic signed [PRIO_W-1:0]  req_priority_req;
   logic                      rsp_valid;
   logic                      rsp_ready;
   logic                      rsp_out_valid;
   logic signed [VALUE_W-1:0] rsp_out_value;
   logic signed [PRIO_W-1:0]  rsp_out_priority;
   logic                      rsp_underflow;
   logic                      rsp_overflow;
   logic [FILL_W-1:0]         rsp_fill_count;

   spq_scoreboard sb = new;
   bit quiet = 1'b0;
   bit hold_pending = 1'b0;
   bit holding = 1'b0;
   int input_stall_cycles = 0;

   sorted_priority_queue #(.DEPTH(DEPTH)) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_op           (req_op),
      .req_value        (req_value),
      .req_priority_req (req_priority_req),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_valid    (rsp_out_valid),
      .rsp_out_value    (rsp_out_value),
      .rsp_out_priority (rsp_out_priority),
      .rsp_underflow    (rsp_underflow),
      .rsp_overflow     (rsp_overflow),
      .rsp_fill_count   (rsp_fill_count)
   );

   always #5 clock = ~clock;

   // Gap length: mostly none or short, now and then long; none in quiet stretches.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 55)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      if (r < 98)
         return $urandom_range(4, 12);
      return $urandom_range(20, 40);
   endfunction

   // Priorities cluster on a few values so that ties are common.
   function automatic logic signed [PRIO_W-1:0] pick_priority();
      int r;
      r = $urandom_range(0, 9);
      if (r < 5)
         return PRIO_W'(int'($urandom_range(0, 4)) - 2);
      if (r == 5)
         return 16'sh7fff;
      if (r == 6)
         return 16'sh8000;
      return PRIO_W'($urandom);
   endfunction

   function automatic logic signed [VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 19))
         0: return 32'sh7fffffff;
         1: return 32'sh80000000;
         2: return '0;
         default: return $urandom;
      endcase
   endfunction

   // Present one request beat after an optional gap and hold it until taken.
   task offer_request(input op_type op, input logic signed [VALUE_W-1:0] value,
                      input logic signed [PRIO_W-1:0] prio);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_value <= value;
      req_priority_req <= prio;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      @(negedge clock);
   endtask

   task wait_for_drain();
      while (sb.owed_results.size() != 0)
         @(negedge clock);
   endtask

   // Result side: random stalls, plus one long hold-off on request.
   initial begin
      int n;
      rsp_ready <= 1'b0;
      @(negedge clock);
      while (reset)
         @(negedge clock);
      forever begin
         if (hold_pending) begin
            hold_pending = 1'b0;
            holding = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            holding = 1'b0;
         end else begin
            n = pick_gap();
            if (n > 0) begin
               rsp_ready <= 1'b0;
               repeat (n) @(negedge clock);
            end
            rsp_ready <= 1'b1;
            n = $urandom_range(1, 12);
            repeat (n) @(negedge clock);
         end
      end
   end

   // Observe both channels at the rising edge.
   always @(posedge clock) begin : beat_monitor
      queue_result_type got;
      if (!reset) begin
         if (req_valid && !req_ready)
            input_stall_cycles++;
         if (req_valid && req_ready)
            sb.note_request(op_type'(req_op), req_value, req_priority_req);
         if (rsp_valid && rsp_ready) begin
            got.out_valid = rsp_out_valid;
            got.out_value = rsp_out_value;
            got.out_priority = rsp_out_priority;
            got.underflow = rsp_underflow;
            got.overflow = rsp_overflow;
            got.fill_count = rsp_fill_count;
            sb.check_response(got);
         end
      end
   end

   initial begin
      #(LIMIT_NS);
      $display("Run did not finish in time; %0d results still outstanding",
               sb.owed_results.size());
      $display("tb_sorted_priority_queue NOT OK");
      $finish;
   end

   initial begin
      logic signed [PRIO_W-1:0]  fill_prio[DEPTH];
      logic signed [VALUE_W-1:0] fill_value[DEPTH];
      int enq_bias;
      int phase;
      int k;
      fill_prio = '{16'sh7fff, 16'sh8000, 16'sh0000, 16'shffff, 16'sh0001, 16'sh0005,
                    16'sh0005, 16'sh0005, 16'sh7fff, 16'sh8000, 16'sh0002, 16'shfffe,
                    16'sh0000, 16'sh0005, 16'sh012c, 16'shfed4};
      fill_value = '{32'sh7fffffff, 32'sh80000000, 32'sh00000000, 32'shffffffff,
                     32'sh00000001, 32'sh00000064, 32'sh00000065, 32'sh00000066,
                     32'sh00000005, 32'sh00000006, 32'sh00000007, 32'sh00000008,
                     32'sh00000009, 32'sh0000000a, 32'sh0000000b, 32'sh0000000c};
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_op <= OP_ENQUEUE;
      req_value <= '0;
      req_priority_req <= '0;
      repeat (2) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: empty dequeue, fill with extremes and ties, overflow, partial drain.
      offer_request(OP_DEQUEUE, 32'sh7fffffff, 16'sh7fff);
      for (k = 0; k < DEPTH; k++)
         offer_request(OP_ENQUEUE, fill_value[k], fill_prio[k]);
      offer_request(OP_ENQUEUE, 32'sh0000000d, 16'sh7fff);
      for (k = 0; k < 6; k++)
         offer_request(OP_DEQUEUE, pick_value(), pick_priority());
      req_valid <= 1'b0;
      wait_for_drain();

      // Random phases that swing the queue between full and empty.
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase % 5)
            0: enq_bias = 90;
            1: enq_bias = 10;
            2: enq_bias = 55;
            3: enq_bias = 45;
            default: enq_bias = $urandom_range(5, 95);
         endcase
         quiet = (phase % 3 == 2);
         // Every fourth phase the sender waits until the block has caught up.
         if (phase % 4 == 3) begin
            req_valid <= 1'b0;
            wait_for_drain();
            @(negedge clock);
         end
         // Once, stall the result side for a long time while requests keep coming.
         if (phase == 6) begin
            req_valid <= 1'b0;
            quiet = 1'b1;
            hold_pending = 1'b1;
            while (!holding)
               @(negedge clock);
         end
         for (k = 0; k < PHASE_ITEMS; k++)
            offer_request(($urandom_range(0, 99) < enq_bias) ? OP_ENQUEUE : OP_DEQUEUE,
                          pick_value(), pick_priority());
      end

      req_valid <= 1'b0;
      wait_for_drain();
      repeat (4) @(negedge clock);

      $display("Covered %0d enqueues and %0d dequeues, %0d overflows, %0d underflows,",
               sb.enqueues, sb.dequeues, sb.overflows, sb.underflows);
      $display("peak fill %0d, %0d results checked, %0d cycles of input backpressure",
               sb.peak_fill, sb.results_checked, input_stall_cycles);
      if (sb.mismatches == 0) begin
         $display("tb_sorted_priority_queue OK");
      end else begin
         $display("%0d mismatches", sb.mismatches);
         $display("tb_sorted_priority_queue NOT OK");
      end
      $finish;
   end

endmodule

[sorted_priority_queue.f]
src/spq_pkg.sv
src/spq_cell.sv
src/sorted_priority_queue.sv
tb/tb_sorted_priority_queue.sv
